// File: src/y2rgb_pkg.sv
package y2rgb_pkg;

  // Channel and field widths
  localparam int unsigned ChanW = 8;
  localparam int unsigned LumaW = ChanW + 1;  // Y - 16 as a signed value
  localparam int unsigned FracW = 16;
  localparam int unsigned AccW  = 28;         // holds every product and sum exactly

  typedef logic [ChanW-1:0]        chan_t;
  typedef logic signed [LumaW-1:0] luma_t;
  typedef logic signed [ChanW-1:0] chroma_t;
  typedef logic signed [AccW-1:0]  acc_t;

  // Folded BT.601 coefficients, unsigned at 2^-16
  localparam acc_t KLuma    = acc_t'(76309);   // 255/219
  localparam acc_t KCrRed   = acc_t'(104597);  // 1.402 * 255/224
  localparam acc_t KCbGreen = acc_t'(25664);   // 0.344 * 255/224
  localparam acc_t KCrGreen = acc_t'(53268);   // 0.714 * 255/224
  localparam acc_t KCbBlue  = acc_t'(132201);  // 1.772 * 255/224

  localparam luma_t LumaOfs = luma_t'(16);
  localparam chan_t ChanMax = {ChanW{1'b1}};

endpackage

// File: src/y2rgb_if.sv
// One YUY2 group per beat
interface y2rgb_grp_if
  import y2rgb_pkg::*;
();
  logic  valid;
  logic  ready;
  chan_t luma_first;
  chan_t chroma_blue;
  chan_t luma_second;
  chan_t chroma_red;

  modport source (
    output valid, luma_first, chroma_blue, luma_second, chroma_red,
    input  ready
  );
  modport sink (
    input  valid, luma_first, chroma_blue, luma_second, chroma_red,
    output ready
  );
endinterface

// Two RGB888 pixels per beat
interface y2rgb_pix_if
  import y2rgb_pkg::*;
();
  logic  valid;
  logic  ready;
  chan_t red_first;
  chan_t green_first;
  chan_t blue_first;
  chan_t red_second;
  chan_t green_second;
  chan_t blue_second;

  modport source (
    output valid, red_first, green_first, blue_first,
           red_second, green_second, blue_second,
    input  ready
  );
  modport sink (
    input  valid, red_first, green_first, blue_first,
           red_second, green_second, blue_second,
    output ready
  );
endinterface

// File: src/yuy2_to_rgb_pixel_pair.sv
// YUY2 to RGB888 converter, BT.601 studio range, one pixel pair per beat.
//
// grp_i takes one YUY2 group (Y0, Cb, Y1, Cr) per beat; pix_o gives the two
// RGB888 pixels that share that chroma. Both are valid/ready channels and a
// beat moves at a clock edge with valid and ready high.
//
// Four register stages: chroma/luma offset, coefficient products, channel
// sums, saturation into the output register. An accepted group passes
// through the stages in that order to pix_o. The pipeline takes one group
// every cycle while pix_o is ready; throughput is one pair per cycle.
//
// Each stage holds its beat while the stage after it is full and stalled,
// and an empty stage fills even when later stages are stalled, so bubbles
// collapse. A stall on pix_o loses and repeats nothing; grp_i.ready drops
// only once every stage is full.
//
// Reset clears all stage valid bits; no group is in flight afterwards.
module yuy2_to_rgb_pixel_pair
  import y2rgb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  y2rgb_grp_if.sink   grp_i,
  y2rgb_pix_if.source pix_o
);

  // Truncate and saturate one channel sum
  function automatic chan_t sat_chan(acc_t acc);
    chan_t res;
    if (acc[AccW-1]) begin
      res = '0;
    end else if (|acc[AccW-2:FracW+ChanW]) begin
      res = ChanMax;
    end else begin
      res = acc[FracW+ChanW-1:FracW];
    end
    return res;
  endfunction

  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

  // A stage loads when empty or when its content moves on
  assign s4_rdy = !s4_vld_q || pix_o.ready;
  assign s3_rdy = !s3_vld_q || s4_rdy;
  assign s2_rdy = !s2_vld_q || s3_rdy;
  assign s1_rdy = !s1_vld_q || s2_rdy;
  assign grp_i.ready = s1_rdy;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld_q <= grp_i.valid;
      if (s2_rdy) s2_vld_q <= s1_vld_q;
      if (s3_rdy) s3_vld_q <= s2_vld_q;
      if (s4_rdy) s4_vld_q <= s3_vld_q;
    end
  end

  // Stage 1: remove luma and chroma offsets
  luma_t   y0_d, y1_d, y0_q, y1_q;
  chroma_t cb_d, cr_d, cb_q, cr_q;

  always_comb begin
    y0_d = $signed({1'b0, grp_i.luma_first}) - LumaOfs;
    y1_d = $signed({1'b0, grp_i.luma_second}) - LumaOfs;
    // x - 128 on a byte is a flip of its top bit
    cb_d = $signed({~grp_i.chroma_blue[ChanW-1], grp_i.chroma_blue[ChanW-2:0]});
    cr_d = $signed({~grp_i.chroma_red[ChanW-1], grp_i.chroma_red[ChanW-2:0]});
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      y0_q <= y0_d;
      y1_q <= y1_d;
      cb_q <= cb_d;
      cr_q <= cr_d;
    end
  end

  // Stage 2: coefficient products
  acc_t ly0_d, ly1_d, pr_d, pgb_d, pgr_d, pb_d;
  acc_t ly0_q, ly1_q, pr_q, pgb_q, pgr_q, pb_q;

  always_comb begin
    ly0_d = acc_t'(y0_q) * KLuma;
    ly1_d = acc_t'(y1_q) * KLuma;
    pr_d  = acc_t'(cr_q) * KCrRed;
    pgb_d = acc_t'(cb_q) * KCbGreen;
    pgr_d = acc_t'(cr_q) * KCrGreen;
    pb_d  = acc_t'(cb_q) * KCbBlue;
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy) begin
      ly0_q <= ly0_d;
      ly1_q <= ly1_d;
      pr_q  <= pr_d;
      pgb_q <= pgb_d;
      pgr_q <= pgr_d;
      pb_q  <= pb_d;
    end
  end

  // Stage 3: channel sums
  acc_t r0_d, g0_d, b0_d, r1_d, g1_d, b1_d;
  acc_t r0_q, g0_q, b0_q, r1_q, g1_q, b1_q;

  always_comb begin
    r0_d = ly0_q + pr_q;
    g0_d = ly0_q - pgb_q - pgr_q;
    b0_d = ly0_q + pb_q;
    r1_d = ly1_q + pr_q;
    g1_d = ly1_q - pgb_q - pgr_q;
    b1_d = ly1_q + pb_q;
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy) begin
      r0_q <= r0_d;
      g0_q <= g0_d;
      b0_q <= b0_d;
      r1_q <= r1_d;
      g1_q <= g1_d;
      b1_q <= b1_d;
    end
  end

  // Stage 4: saturate into the output register
  chan_t red0_q, grn0_q, blu0_q, red1_q, grn1_q, blu1_q;

  always_ff @(posedge clk_i) begin
    if (s4_rdy) begin
      red0_q <= sat_chan(r0_q);
      grn0_q <= sat_chan(g0_q);
      blu0_q <= sat_chan(b0_q);
      red1_q <= sat_chan(r1_q);
      grn1_q <= sat_chan(g1_q);
      blu1_q <= sat_chan(b1_q);
    end
  end

  assign pix_o.valid        = s4_vld_q;
  assign pix_o.red_first    = red0_q;
  assign pix_o.green_first  = grn0_q;
  assign pix_o.blue_first   = blu0_q;
  assign pix_o.red_second   = red1_q;
  assign pix_o.green_second = grn1_q;
  assign pix_o.blue_second  = blu1_q;

  // An accepted group lands in stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_i.valid && grp_i.ready |=> s1_vld_q)
    else $error("accepted group did not reach stage 1");

  // A stalled sum stage keeps its beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_vld_q && !s3_rdy |=> s3_vld_q && $stable(r0_q) && $stable(g1_q))
    else $error("stalled sum stage lost its beat");

  // Input may only stall when the whole pipeline is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !grp_i.ready |-> s1_vld_q && s2_vld_q && s3_vld_q && s4_vld_q)
    else $error("input stalled with a free stage");

  // A negative red sum gives black red
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_vld_q && s4_rdy && r0_q[AccW-1] |=> pix_o.red_first == '0)
    else $error("negative red sum not clamped to zero");

endmodule
